### rtl/rblit_pkg.sv
// Shared types, constants and the pixel packing function of the rectangle blit.
package rblit_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int CFG_COORD_W  = 12;
  localparam int CFG_STRIDE_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int PIXEL_IN_W   = 32;
  localparam int PIXEL_OUT_W  = 16;
  localparam int OUT_OFFSET_W = 32;
  localparam int CHANNEL_SHIFT = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_SRC_STRIDE  = 3'd4,
    REG_DST_STRIDE  = 3'd5,
    REG_DST_X       = 3'd6,
    REG_DST_Y       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_COORD_W-1:0]  rect_left;
    logic [CFG_COORD_W-1:0]  rect_top;
    logic [CFG_COORD_W-1:0]  rect_right;
    logic [CFG_COORD_W-1:0]  rect_bottom;
    logic [CFG_STRIDE_W-1:0] src_stride;
    logic [CFG_STRIDE_W-1:0] dst_stride;
    logic [CFG_COORD_W-1:0]  dst_x;
    logic [CFG_COORD_W-1:0]  dst_y;
  } cfg_t;

  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] src_offset;
    logic [OUT_OFFSET_W-1:0] dst_offset;
    logic [PIXEL_OUT_W-1:0]  out_pixel;
    logic                    last_pixel;
  } res_t;

  // Alpha keeps only its low bit; each color channel keeps its top five bits.
  function automatic logic [PIXEL_OUT_W-1:0] pack_1555(input logic [PIXEL_IN_W-1:0] p);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = p[16+CHANNEL_SHIFT +: 5];
    g = p[8+CHANNEL_SHIFT +: 5];
    b = p[CHANNEL_SHIFT +: 5];
    return {p[24], r, g, b};
  endfunction

endpackage

### rtl/rblit_cfg.sv
// Configuration register file of the rectangle blit.
module rblit_cfg
  import rblit_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg,
  output cfg_t                   cfg_next
);

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RECT_LEFT:   cfg_next.rect_left   = cfg_data[CFG_COORD_W-1:0];
        REG_RECT_TOP:    cfg_next.rect_top    = cfg_data[CFG_COORD_W-1:0];
        REG_RECT_RIGHT:  cfg_next.rect_right  = cfg_data[CFG_COORD_W-1:0];
        REG_RECT_BOTTOM: cfg_next.rect_bottom = cfg_data[CFG_COORD_W-1:0];
        REG_SRC_STRIDE:  cfg_next.src_stride  = cfg_data[CFG_STRIDE_W-1:0];
        REG_DST_STRIDE:  cfg_next.dst_stride  = cfg_data[CFG_STRIDE_W-1:0];
        REG_DST_X:       cfg_next.dst_x       = cfg_data[CFG_COORD_W-1:0];
        REG_DST_Y:       cfg_next.dst_y       = cfg_data[CFG_COORD_W-1:0];
        default:         cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

### rtl/rblit_walk.sv
// Raster walk counters, row base offsets and per-pixel result computation.
module rblit_walk
  import rblit_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cfg_t                  cfg_next,
  input  logic                  cfg_load,
  input  logic                  step,
  input  logic [PIXEL_IN_W-1:0] src_pixel,
  output res_t                  res
);

  localparam int PROD_W = COORD_BITS + CFG_STRIDE_W;

  logic [COORD_BITS-1:0]  cur_col;
  logic [COORD_BITS-1:0]  cur_row;
  logic [OFFSET_BITS-1:0] src_row_base;
  logic [OFFSET_BITS-1:0] dst_row_base;
  logic [OFFSET_BITS-1:0] src_base0;
  logic [OFFSET_BITS-1:0] dst_base0;

  logic [PROD_W-1:0]      src_prod;
  logic [PROD_W-1:0]      dst_prod;
  logic [COORD_BITS-1:0]  left;
  logic [COORD_BITS-1:0]  right;
  logic [COORD_BITS-1:0]  bottom;
  logic [COORD_BITS-1:0]  rel;
  logic [COORD_BITS:0]    dcol;
  logic [OFFSET_BITS-1:0] src_off;
  logic [OFFSET_BITS-1:0] dst_off;
  logic                   row_end;
  logic                   last;

  // Start-of-walk row bases, taken from the values the registers are about to hold.
  assign src_prod = PROD_W'(COORD_BITS'(cfg_next.rect_top)) * PROD_W'(cfg_next.src_stride);
  assign dst_prod = PROD_W'(COORD_BITS'(cfg_next.dst_y)) * PROD_W'(cfg_next.dst_stride);

  assign left    = COORD_BITS'(cfg.rect_left);
  assign right   = COORD_BITS'(cfg.rect_right);
  assign bottom  = COORD_BITS'(cfg.rect_bottom);
  assign rel     = cur_col - left;
  assign dcol    = (COORD_BITS+1)'(COORD_BITS'(cfg.dst_x)) + (COORD_BITS+1)'(rel);
  assign src_off = src_row_base + OFFSET_BITS'({cur_col, 2'b00});
  assign dst_off = dst_row_base + OFFSET_BITS'({dcol, 1'b0});
  assign row_end = cur_col >= right;
  assign last    = row_end && (cur_row >= bottom);

  always_comb begin
    res.src_offset = OUT_OFFSET_W'(src_off);
    res.dst_offset = OUT_OFFSET_W'(dst_off);
    res.out_pixel  = pack_1555(src_pixel);
    res.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_base0 <= '0;
      dst_base0 <= '0;
    end else begin
      src_base0 <= OFFSET_BITS'(src_prod);
      dst_base0 <= OFFSET_BITS'(dst_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      src_row_base <= '0;
      dst_row_base <= '0;
    end else if (cfg_load) begin
      cur_col      <= COORD_BITS'(cfg_next.rect_left);
      cur_row      <= COORD_BITS'(cfg_next.rect_top);
      src_row_base <= OFFSET_BITS'(src_prod);
      dst_row_base <= OFFSET_BITS'(dst_prod);
    end else if (step) begin
      if (last) begin
        cur_col      <= left;
        cur_row      <= COORD_BITS'(cfg.rect_top);
        src_row_base <= src_base0;
        dst_row_base <= dst_base0;
      end else if (row_end) begin
        cur_col      <= left;
        cur_row      <= cur_row + COORD_BITS'(1);
        src_row_base <= src_row_base + OFFSET_BITS'(cfg.src_stride);
        dst_row_base <= dst_row_base + OFFSET_BITS'(cfg.dst_stride);
      end else begin
        cur_col <= cur_col + COORD_BITS'(1);
      end
    end
  end

endmodule

### rtl/rblit_outbuf.sv
// Output register with a skid stage so the input keeps flowing under a short stall.
module rblit_outbuf
  import rblit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  res_t din,
  output logic out_valid,
  input  logic out_stall,
  output res_t dout
);

  logic skid_valid;
  res_t skid;
  logic accept_in;
  logic take;
  logic refill;

  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !skid_valid;
  assign take      = out_valid && !out_stall;
  assign refill    = !out_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (refill) begin
      out_valid  <= skid_valid || accept_in;
      skid_valid <= 1'b0;
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (refill) begin
      if (skid_valid) begin
        dout <= skid;
      end else if (accept_in) begin
        dout <= din;
      end
    end else if (accept_in) begin
      skid <= din;
    end
  end

endmodule

### rtl/rect_blit_argb8888_to_argb1555.sv
// A result beat is registered into the output register, or into the skid entry while the output is stalled.
// Throughput: one pixel per cycle unless in_stall is high; walk counters and row bases advance by one add each.
// A two-entry output stage (register plus skid) raises in_stall only when both are full.
// Reset is synchronous: walk and config registers go to zero, the walk starts at the top-left corner,
// and the output stage is empty. A register write rewinds the walk to the new rectangle's top-left corner.
module rect_blit_argb8888_to_argb1555
  import rblit_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIXEL_IN_W-1:0]   src_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_OFFSET_W-1:0] src_offset,
  output logic [OUT_OFFSET_W-1:0] dst_offset,
  output logic [PIXEL_OUT_W-1:0]  out_pixel,
  output logic                    last_pixel
);

  cfg_t cfg;
  cfg_t cfg_next;
  res_t res;
  res_t res_out;
  logic step;

  assign step = in_valid && !in_stall;

  rblit_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_next  (cfg_next)
  );

  rblit_walk #(
    .COORD_BITS  (COORD_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_next  (cfg_next),
    .cfg_load  (cfg_we),
    .step      (step),
    .src_pixel (src_pixel),
    .res       (res)
  );

  rblit_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .din       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign src_offset = res_out.src_offset;
  assign dst_offset = res_out.dst_offset;
  assign out_pixel  = res_out.out_pixel;
  assign last_pixel = res_out.last_pixel;

`ifndef SYNTH
  // The input is held off only while a result is already waiting at the output.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output stage");

  // After an accepted beat the output always holds a valid result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // Accepting while the output is held must fill the skid entry.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && out_valid && out_stall) |=> in_stall)
    else $error("beat accepted under output stall was not kept");
`endif

endmodule
